// ----- sv/sps_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sps_pkg: shared types and constants of the scheduling policy selector
// Item and result payloads, register indexes, policy codes and the job record
// that travels from the classify front end to the state-keeping back end.
// ----------------------------------------------------------------------------
package sps_pkg;

  // Width of the tick and switch counters (8 .. 32)
  localparam int CNT_W   = 16;
  // Compare width: wide enough for both the counters and the 16-bit interval
  localparam int CMP_W   = (CNT_W > 16) ? CNT_W : 16;
  localparam int SCORE_W = 14;
  localparam int NPOL    = 4;

  localparam logic [SCORE_W-1:0] CONF_CAP = 14'd10000;

  // Configuration register indexes
  localparam logic [1:0] CFG_ENGINE_SELECT = 2'd0;
  localparam logic [1:0] CFG_HYSTERESIS    = 2'd1;
  localparam logic [1:0] CFG_EVAL_INTERVAL = 2'd2;
  localparam logic [1:0] CFG_BUCKET_TABLE  = 2'd3;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_EVAL  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    POL_HP  = 2'd0,
    POL_RM  = 2'd1,
    POL_EDF = 2'd2,
    POL_MC  = 2'd3
  } policy_t;

  typedef enum logic {
    ENG_RULES = 1'b0,
    ENG_TABLE = 1'b1
  } engine_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [13:0] util_bp;
    logic [13:0] miss_rate_bp;
    logic [13:0] hi_crit_ratio_bp;
    logic [15:0] mode_sw_cnt;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  recommended_policy;
    logic [13:0] conf_score;
    logic [1:0]  active_pol;
    logic        switched;
    logic        eval_due;
    logic [15:0] switch_count;
  } out_item_t;

  typedef struct packed {
    engine_t     engine_select;
    logic [13:0] hyst_margin;
    logic [15:0] tick_period;
    logic [31:0] bucket_table;
  } cfg_t;

  // Classified item: mode plus all four scores and the winner
  typedef struct packed {
    logic [1:0]                      mode;
    policy_t                         rec;
    logic [SCORE_W-1:0]              conf;
    logic [NPOL-1:0][SCORE_W-1:0]    score;
  } job_t;

endpackage
`default_nettype wire

// ----- sv/sps_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sps_front: item classifier and policy scorer
// Scores the four policies by threshold rules or the bucket table and picks
// the winner, lowest code on a tie.
// ----------------------------------------------------------------------------
module sps_front
  import sps_pkg::*;
(
  input  in_item_t in_item,
  input  cfg_t     cfg,
  output job_t     job
);

  logic [13:0]        u, m, c;
  logic [SCORE_W-1:0] r0, r1, r2, r3;
  logic [SCORE_W-1:0] sc [NPOL];
  logic [1:0]         ub, cb;
  logic [3:0]         bidx;
  logic [1:0]         pick;
  logic [SCORE_W-1:0] best;
  policy_t            rec;

  assign u = in_item.util_bp;
  assign m = in_item.miss_rate_bp;
  assign c = in_item.hi_crit_ratio_bp;

  // Threshold rules
  always_comb begin
    logic [SCORE_W-1:0] t1, t3;
    r0 = 14'd2000;
    if (u > 14'd5000 && u < 14'd8500) r0 = r0 + 14'd1500;
    if (c < 14'd2000) r0 = r0 + 14'd1000;

    t1 = (u < 14'd5000) ? 14'd3000 : ((u < 14'd7000) ? 14'd1500 : 14'd0);
    if (m < 14'd100) t1 = t1 + 14'd2000;
    if (u > 14'd8000) t1 = (t1 > 14'd1500) ? t1 - 14'd1500 : 14'd0;
    r1 = t1;

    r2 = (u > 14'd8500) ? 14'd3000 : ((u > 14'd6000) ? 14'd2000 : 14'd0);
    r2 = r2 + ((m > 14'd500) ? 14'd3000 : ((m > 14'd100) ? 14'd1500 : 14'd0));

    t3 = (c > 14'd4000) ? 14'd4000 : ((c > 14'd2000) ? 14'd2000 : 14'd0);
    if (in_item.mode_sw_cnt != 16'd0) t3 = t3 + 14'd1000;
    if (c < 14'd1000) t3 = (t3 > 14'd2000) ? t3 - 14'd2000 : 14'd0;
    r3 = t3;
  end

  // Bucket lookup: value / 2500 capped at three
  always_comb begin
    ub = (u >= 14'd7500) ? 2'd3 : (u >= 14'd5000) ? 2'd2 : (u >= 14'd2500) ? 2'd1 : 2'd0;
    cb = (c >= 14'd7500) ? 2'd3 : (c >= 14'd5000) ? 2'd2 : (c >= 14'd2500) ? 2'd1 : 2'd0;
    bidx = {ub, cb};
    pick = cfg.bucket_table[{bidx, 1'b0} +: 2];
  end

  always_comb begin
    for (int i = 0; i < NPOL; i++) begin
      if (cfg.engine_select == ENG_TABLE) begin
        sc[i] = (pick == 2'(i)) ? 14'd7500 : 14'd2500;
      end else begin
        case (i)
          0:       sc[i] = r0;
          1:       sc[i] = r1;
          2:       sc[i] = r2;
          default: sc[i] = r3;
        endcase
      end
    end
  end

  // Argmax, strict compare keeps the lowest code on a tie
  always_comb begin
    best = '0;
    rec  = POL_HP;
    for (int i = 0; i < NPOL; i++) begin
      if (sc[i] > best) begin
        best = sc[i];
        rec  = policy_t'(2'(i));
      end
    end
  end

  always_comb begin
    job.mode = in_item.mode;
    job.rec  = rec;
    job.conf = (best > CONF_CAP) ? CONF_CAP : best;
    for (int i = 0; i < NPOL; i++) begin
      job.score[i] = sc[i];
    end
  end

endmodule
`default_nettype wire

// ----- sv/sps_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sps_queue: two-entry job queue
// Decouples the scorer from the state update so that each side stalls alone.
// ----------------------------------------------------------------------------
module sps_queue
  import sps_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_job
);

  job_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push, pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_job    = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

// ----- sv/sps_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sps_back: policy state and result register
// Applies ticks, evaluations and clears to the policy state and holds one
// result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module sps_back
  import sps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      job_valid,
  output logic      job_ready,
  input  job_t      job,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  policy_t          cur_pol_r, cur_pol_nxt;
  logic [CNT_W-1:0] tick_r, tick_nxt;
  logic [CNT_W-1:0] sw_total_r, sw_total_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic             take;
  logic [CNT_W-1:0] tick_inc;
  logic [CMP_W-1:0] tick_ext, lim_ext, sw_ext;
  logic [15:0]      lim;
  logic [14:0]      cur_plus_hyst;
  logic             do_switch;

  assign job_ready = !out_valid_r || out_ready;
  assign take      = job_valid && job_ready;

  always_comb begin
    lim           = (cfg.tick_period == 16'd0) ? 16'd1 : cfg.tick_period;
    tick_inc      = (tick_r == {CNT_W{1'b1}}) ? tick_r : tick_r + 1'b1;
    tick_ext      = CMP_W'(tick_inc);
    lim_ext       = CMP_W'(lim);
    cur_plus_hyst = {1'b0, job.score[cur_pol_r]} + {1'b0, cfg.hyst_margin};
    do_switch     = (job.rec != cur_pol_r) && ({1'b0, job.conf} > cur_plus_hyst);
  end

  // State update for the item taken this cycle
  always_comb begin
    cur_pol_nxt  = cur_pol_r;
    tick_nxt     = tick_r;
    sw_total_nxt = sw_total_r;
    out_data_nxt = out_data_r;
    if (take) begin
      out_data_nxt.recommended_policy = 2'd0;
      out_data_nxt.conf_score         = '0;
      out_data_nxt.switched           = 1'b0;
      out_data_nxt.eval_due           = 1'b0;
      case (job.mode)
        MODE_TICK: begin
          if (tick_ext >= lim_ext) begin
            tick_nxt              = '0;
            out_data_nxt.eval_due = 1'b1;
          end else begin
            tick_nxt = tick_inc;
          end
        end
        MODE_EVAL: begin
          out_data_nxt.recommended_policy = job.rec;
          out_data_nxt.conf_score         = job.conf;
          if (do_switch) begin
            cur_pol_nxt           = job.rec;
            sw_total_nxt          = (sw_total_r == {CNT_W{1'b1}}) ? sw_total_r
                                                                  : sw_total_r + 1'b1;
            out_data_nxt.switched = 1'b1;
          end
        end
        MODE_CLEAR: begin
          cur_pol_nxt  = POL_HP;
          tick_nxt     = '0;
          sw_total_nxt = '0;
        end
        default: begin
        end
      endcase
      sw_ext                     = CMP_W'(sw_total_nxt);
      out_data_nxt.active_pol    = cur_pol_nxt;
      out_data_nxt.switch_count  = sw_ext[15:0];
    end else begin
      sw_ext = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_pol_r   <= POL_HP;
      tick_r      <= '0;
      sw_total_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_pol_r   <= cur_pol_nxt;
      tick_r      <= tick_nxt;
      sw_total_r  <= sw_total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ----- sv/scheduling_policy_selector.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// scheduling_policy_selector: adaptive scheduling policy selector
// Ticks an evaluation interval and scores four scheduling policies, switching
// the active one only past a hysteresis margin.
// ----------------------------------------------------------------------------
// The block takes one item per cycle unless the queue is full and returns
// exactly one result beat per item, in order. A tick (mode 0) advances the
// interval counter and flags eval_due when the interval is reached; an
// evaluation (mode 1) scores the four policies and may switch the active
// one; a clear (mode 2) returns the policy state to reset while keeping the
// configuration. An accepted item passes through the queue and the result
// register before its result shows. Throughput is one item per cycle while
// out_ready holds, set by the result register: the front end scores an item
// in the cycle it arrives and pushes it into a two-entry queue, and the back
// end pops one job per cycle into the result register whenever that
// register is empty or being drained. Write configuration only while no
// item is in flight.
module scheduling_policy_selector
  import sps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  // Configuration registers
  cfg_t cfg_r, cfg_nxt;

  // Front to queue, queue to back
  job_t front_job;
  job_t q_job;
  logic q_valid;
  logic q_ready;
  logic q_job_ready;

  // Decode configuration writes; an index lands on exactly one register
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_ENGINE_SELECT: cfg_nxt.engine_select = engine_t'(cfg_wdata[0]);
        CFG_HYSTERESIS:    cfg_nxt.hyst_margin   = cfg_wdata[13:0];
        CFG_EVAL_INTERVAL: cfg_nxt.tick_period   = cfg_wdata[15:0];
        CFG_BUCKET_TABLE:  cfg_nxt.bucket_table  = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.engine_select <= ENG_RULES;
      cfg_r.hyst_margin   <= 14'd500;
      cfg_r.tick_period   <= 16'd100;
      cfg_r.bucket_table  <= 32'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Score and pick the winner as the beat arrives
  sps_front u_front (
    .in_item (in_data),
    .cfg     (cfg_r),
    .job     (front_job)
  );

  // Hold scored jobs so input and output stall independently
  sps_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (q_ready),
    .push_job   (front_job),
    .pop_valid  (q_valid),
    .pop_ready  (q_job_ready),
    .pop_job    (q_job)
  );

  assign in_ready = q_ready;

  // Advance policy state and register the result beat
  sps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job_valid (q_valid),
    .job_ready (q_job_ready),
    .job       (q_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A switch always lands on the recommended policy
  a_switch_to_rec: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.switched) |->
      (out_data.active_pol == out_data.recommended_policy))
    else $error("switch did not adopt recommended policy");

  // A due flag only comes from a tick, which recommends nothing
  a_due_is_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.eval_due) |->
      (!out_data.switched && out_data.conf_score == 14'd0 &&
       out_data.recommended_policy == 2'd0))
    else $error("eval_due set on a non-tick result");

  // A switch leaves a nonzero switch count behind it
  a_switch_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.switched) |-> (out_data.switch_count != 16'd0))
    else $error("switch not counted");

  // A result beat taken with no queued job leaves the result register empty
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !q_valid) |=> !out_valid)
    else $error("result beat repeated");

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: scheduling policy selector
// A queue-fed driver sends ticks, evaluations, clears and undefined modes
// through the input channel. Randomly sized gaps and stalls are applied on
// both sides. Each accepted beat is run through a behavioral predictor, and
// each result beat is checked field by field against the oldest prediction.
// Configuration changes between phases, and only while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
  import sps_pkg::*;

  // The package has no name for the fourth mode, which the block must ignore
  localparam logic [1:0] MODE_UNDEF = 2'd3;
  // Cycles without any beat or register write before the run is declared hung
  localparam int WATCHDOG_LIMIT = 2000;
  // Rule and bucket thresholds and the cap; random values cluster around them
  localparam int BP_EDGES [13] = '{100, 500, 1000, 2000, 2500, 4000, 5000,
                                  6000, 7000, 7500, 8000, 8500, 10000};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = CFG_ENGINE_SELECT;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;

  // Register copies and policy state of the predictor
  engine_t          eng_sel;
  logic [13:0]      hyst_bp;
  logic [15:0]      eval_period;
  logic [31:0]      bucket_map;
  policy_t          cur_policy;
  logic [CNT_W-1:0] tick_cnt;
  logic [CNT_W-1:0] switch_total;

  in_item_t    pending_items[$];
  out_item_t   expected_results[$];
  int unsigned error_count = 0;
  bit          no_gaps = 1'b0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;

  always #4 clk = ~clk;

  scheduling_policy_selector i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Advance the predicted policy state by one input beat and return the
  // result beat it should produce.
  function automatic out_item_t predict_selection(in_item_t it);
    int unsigned u, m, c, ub, cb, best, lim;
    int unsigned sc [NPOL];
    int          rec;
    policy_t     pick;
    out_item_t   res;
    u = it.util_bp;
    m = it.miss_rate_bp;
    c = it.hi_crit_ratio_bp;
    res = '0;
    best = 0;
    rec = 0;
    case (it.mode)
      MODE_TICK: begin
        // A zero interval behaves like an interval of one
        lim = (eval_period == 0) ? 1 : eval_period;
        if (tick_cnt != '1) tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= lim) begin
          tick_cnt = '0;
          res.eval_due = 1'b1;
        end
      end
      MODE_EVAL: begin
        if (eng_sel == ENG_TABLE) begin
          // Buckets of 2500 bp, saturating at 3 for out-of-range values
          ub = (u / 2500 > 3) ? 3 : u / 2500;
          cb = (c / 2500 > 3) ? 3 : c / 2500;
          pick = policy_t'(bucket_map[2 * (4 * ub + cb) +: 2]);
          foreach (sc[i]) sc[i] = (i == pick) ? 7500 : 2500;
        end else begin
          sc[POL_HP] = 2000;
          if (u > 5000 && u < 8500) sc[POL_HP] += 1500;
          if (c < 2000) sc[POL_HP] += 1000;
          sc[POL_RM] = (u < 5000) ? 3000 : (u < 7000) ? 1500 : 0;
          if (m < 100) sc[POL_RM] += 2000;
          if (u > 8000) sc[POL_RM] = (sc[POL_RM] > 1500) ? sc[POL_RM] - 1500 : 0;
          sc[POL_EDF] = ((u > 8500) ? 3000 : (u > 6000) ? 2000 : 0)
                      + ((m > 500) ? 3000 : (m > 100) ? 1500 : 0);
          sc[POL_MC] = ((c > 4000) ? 4000 : (c > 2000) ? 2000 : 0)
                     + ((it.mode_sw_cnt != 0) ? 1000 : 0);
          if (c < 1000) sc[POL_MC] = (sc[POL_MC] > 2000) ? sc[POL_MC] - 2000 : 0;
        end
        // Strict compare: ties stay with the lowest policy code
        foreach (sc[i]) if (sc[i] > best) begin
          best = sc[i];
          rec = i;
        end
        res.recommended_policy = 2'(rec);
        res.conf_score = 14'((best > CONF_CAP) ? CONF_CAP : best);
        if (rec != cur_policy && sc[rec] > sc[cur_policy] + hyst_bp) begin
          cur_policy = policy_t'(2'(rec));
          if (switch_total != '1) switch_total = switch_total + 1'b1;
          res.switched = 1'b1;
        end
      end
      MODE_CLEAR: begin
        cur_policy = POL_HP;
        tick_cnt = '0;
        switch_total = '0;
      end
      default: begin
        // Undefined mode: leave the state alone
      end
    endcase
    res.active_pol = cur_policy;
    res.switch_count = 16'(switch_total);
    return res;
  endfunction

  // Mostly no gap, some short ones, a few long ones
  function automatic int unsigned next_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [13:0] rand_bp();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 5) return 14'($urandom_range(10000));
    if (r < 8) return 14'(BP_EDGES[$urandom_range(12)] + $urandom_range(2) - 1);
    return 14'($urandom_range(16383, 10001));
  endfunction

  function automatic void add_item(logic [1:0] mode, int unsigned u, int unsigned m,
                                   int unsigned c, int unsigned ms);
    in_item_t it;
    it.mode = mode;
    it.util_bp = 14'(u);
    it.miss_rate_bp = 14'(m);
    it.hi_crit_ratio_bp = 14'(c);
    it.mode_sw_cnt = 16'(ms);
    pending_items.push_back(it);
  endfunction

  function automatic void add_random_item();
    int unsigned r, ms;
    logic [1:0]  mode;
    r = $urandom_range(99);
    mode = (r < 50) ? MODE_EVAL : (r < 88) ? MODE_TICK : (r < 95) ? MODE_CLEAR : MODE_UNDEF;
    r = $urandom_range(9);
    ms = (r < 5) ? 0 : (r < 6) ? 65535 : $urandom_range(65535, 1);
    add_item(mode, rand_bp(), rand_bp(), rand_bp(), ms);
  endfunction

  // One register write beat; the caller guarantees the block is idle
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold until every queued beat is sent and every result has come back,
  // then let the pipeline settle.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // Register copies: reset values, then track every write beat
  always @(posedge clk) begin
    if (!rst_n) begin
      eng_sel <= ENG_RULES;
      hyst_bp <= 14'd500;
      eval_period <= 16'd100;
      bucket_map <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_ENGINE_SELECT: eng_sel <= engine_t'(cfg_wdata[0]);
        CFG_HYSTERESIS:    hyst_bp <= cfg_wdata[13:0];
        CFG_EVAL_INTERVAL: eval_period <= cfg_wdata[15:0];
        CFG_BUCKET_TABLE:  bucket_map <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Driver: predict each accepted beat, hold a stalled beat, otherwise wait
  // out the gap and then pop the next pending item.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
      // Predicted policy state lives with the predictor that advances it
      cur_policy = POL_HP;
      tick_cnt = '0;
      switch_total = '0;
    end else begin
      if (in_valid && in_ready) expected_results.push_back(predict_selection(in_data));
      if (in_valid && !in_ready) begin
        // hold valid and payload until accepted
      end else if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
        send_gap <= next_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each result beat and throttle out_ready with random stalls
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat arrived with no prediction pending");
          error_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("recommended_policy", want.recommended_policy,
                      out_data.recommended_policy);
          check_field("conf_score", want.conf_score, out_data.conf_score);
          check_field("active_pol", want.active_pol, out_data.active_pol);
          check_field("switched", want.switched, out_data.switched);
          check_field("eval_due", want.eval_due, out_data.eval_due);
          check_field("switch_count", want.switch_count, out_data.switch_count);
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall_left <= next_gap();
      end
    end
  end

  // Watchdog: any beat or register write counts as progress
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Stimulus sequence
  initial begin
    int unsigned hyst_pick;
    logic [15:0] period_pick;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset configuration: rule scoring, hysteresis 500
    add_item(MODE_EVAL, 0, 0, 0, 0);               // low load: rate monotonic wins
    add_item(MODE_EVAL, 0, 100, 0, 0);             // tie between codes 0 and 1
    add_item(MODE_EVAL, 9000, 600, 0, 0);          // heavy load: earliest deadline
    add_item(MODE_EVAL, 16383, 16383, 16383, 65535); // all fields at their maximum
    add_item(MODE_EVAL, 10000, 10000, 10000, 1);
    add_item(MODE_EVAL, 5000, 100, 2000, 0);       // exactly on thresholds
    add_item(MODE_EVAL, 8500, 500, 4000, 0);
    add_item(MODE_EVAL, 7000, 101, 4001, 65535);   // mixed criticality
    add_item(MODE_EVAL, 8001, 99, 999, 0);         // both penalties apply
    add_item(MODE_TICK, 0, 0, 0, 0);
    add_item(MODE_TICK, 16383, 16383, 16383, 65535);
    add_item(MODE_UNDEF, 16383, 16383, 16383, 65535); // undefined mode is ignored
    add_item(MODE_CLEAR, 0, 0, 0, 0);
    add_item(MODE_EVAL, 6001, 499, 2001, 1);
    wait_idle();

    // Directed, table lookup with zero hysteresis and a zero interval
    write_reg(CFG_ENGINE_SELECT, ENG_TABLE);
    write_reg(CFG_HYSTERESIS, 32'd0);
    write_reg(CFG_EVAL_INTERVAL, 32'd0);
    write_reg(CFG_BUCKET_TABLE, 32'h9C63_B1E4);
    add_item(MODE_EVAL, 0, 0, 0, 0);
    add_item(MODE_EVAL, 2499, 0, 2500, 0);
    add_item(MODE_EVAL, 2500, 0, 7499, 0);
    add_item(MODE_EVAL, 5000, 0, 2499, 0);
    add_item(MODE_EVAL, 7500, 0, 10000, 0);
    add_item(MODE_EVAL, 16383, 0, 16383, 0);       // buckets saturate at 3
    add_item(MODE_EVAL, 10000, 0, 0, 0);
    add_item(MODE_EVAL, 0, 0, 16383, 0);
    add_item(MODE_TICK, 0, 0, 0, 0);               // due on every tick
    add_item(MODE_TICK, 0, 0, 0, 0);
    wait_idle();

    // Random phases, each with its own configuration
    for (int phase = 0; phase < 8; phase++) begin
      hyst_pick = (phase == 2) ? 0 : (phase == 6) ? 10000 :
                  ($urandom_range(1) != 0) ? 500 : $urandom_range(10000);
      period_pick = (phase == 0) ? 16'd1 : (phase == 7) ? 16'd65535 :
                    16'($urandom_range(8, 1));
      write_reg(CFG_ENGINE_SELECT, (phase == 0) ? ENG_RULES : 32'($urandom_range(1)));
      write_reg(CFG_HYSTERESIS, hyst_pick);
      write_reg(CFG_EVAL_INTERVAL, period_pick);
      write_reg(CFG_BUCKET_TABLE, $urandom());
      // Run some phases back to back with no idling at all
      no_gaps = (phase == 1 || phase == 5);
      for (int n = 0; n < 50; n++) begin
        add_random_item();
        // Stop sending halfway and drain everything before continuing
        if (phase == 3 && n == 24) wait_idle();
      end
      wait_idle();
    end

    repeat (16) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
